// ===== hw/rtl/dwps_pkg.sv =====
`default_nettype none

package dwps_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned ErrW    = 16;
  localparam int unsigned DriveW  = 10;
  localparam int unsigned TargetW = 12;
  localparam int unsigned GainW   = 8;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 16;

  localparam logic [DriveW-1:0]  DriveMax    = 10'h3FF;
  localparam logic [PeriodW-1:0] PeriodReset = 16'd5000;

  // configuration register map
  localparam logic [CfgIdxW-1:0] RegTarget  = 4'd0;
  localparam logic [CfgIdxW-1:0] RegPeriod  = 4'd1;
  localparam logic [CfgIdxW-1:0] RegRightKp = 4'd2;
  localparam logic [CfgIdxW-1:0] RegRightKi = 4'd3;
  localparam logic [CfgIdxW-1:0] RegRightKd = 4'd4;
  localparam logic [CfgIdxW-1:0] RegLeftKp  = 4'd5;
  localparam logic [CfgIdxW-1:0] RegLeftKi  = 4'd6;
  localparam logic [CfgIdxW-1:0] RegLeftKd  = 4'd7;

  typedef struct packed {
    logic load;      // word accepted into the front stage
    logic tick_upd;  // accepted word runs a control update
    logic adv;       // front stage moves to the output stage
    logic s1_upd;    // word in the front stage runs an update
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dwps_lane.sv =====
`default_nettype none

module dwps_lane (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire dwps_pkg::lane_ctrl_t           ctrl,
  input  wire logic                           level,
  input  wire logic [dwps_pkg::TargetW-1:0]   target,
  input  wire logic [dwps_pkg::GainW-1:0]     kp,
  input  wire logic [dwps_pkg::GainW-1:0]     ki,
  input  wire logic [dwps_pkg::GainW-1:0]     kd,
  output logic      [dwps_pkg::DriveW-1:0]    drive,
  output logic      [dwps_pkg::DriveW-1:0]    drive_next,
  output logic      [dwps_pkg::CountW-1:0]    pulses
);

  localparam int unsigned ProdW = dwps_pkg::ErrW + dwps_pkg::GainW + 1;
  localparam int unsigned AccW  = ProdW + 2;

  // front stage state
  logic                                armed;
  logic [dwps_pkg::CountW-1:0]         count;
  logic [dwps_pkg::CountW-1:0]         last_count;
  logic [dwps_pkg::ErrW-1:0]           prev_error;
  logic signed [dwps_pkg::ErrW-1:0]    error_sum;

  // front stage payload for the PID stage
  logic signed [dwps_pkg::ErrW-1:0]    s1_err;
  logic signed [dwps_pkg::ErrW-1:0]    s1_sum;
  logic signed [dwps_pkg::ErrW-1:0]    s1_diff;

  logic [dwps_pkg::CountW-1:0]         count_next;
  logic [dwps_pkg::CountW-1:0]         interval;
  logic [dwps_pkg::ErrW-1:0]           err_bits;
  logic [dwps_pkg::ErrW-1:0]           diff_bits;
  logic signed [dwps_pkg::ErrW:0]      sum_wide;
  logic signed [dwps_pkg::ErrW-1:0]    sum_sat;

  logic signed [dwps_pkg::GainW:0]     kp_s;
  logic signed [dwps_pkg::GainW:0]     ki_s;
  logic signed [dwps_pkg::GainW:0]     kd_s;
  logic signed [ProdW-1:0]             p_term;
  logic signed [ProdW-1:0]             i_term;
  logic signed [ProdW-1:0]             d_term;
  logic signed [AccW-1:0]              acc;
  logic [dwps_pkg::DriveW-1:0]         clamped;

  always_comb begin
    count_next = (level && armed) ? count + {{(dwps_pkg::CountW-1){1'b0}}, 1'b1} : count;
    interval   = count_next - last_count;
    err_bits   = {{(dwps_pkg::ErrW-dwps_pkg::TargetW){1'b0}}, target} - interval;
    diff_bits  = err_bits - prev_error;
    sum_wide   = {error_sum[dwps_pkg::ErrW-1], error_sum}
               + {err_bits[dwps_pkg::ErrW-1], err_bits};
    // saturate when the two top bits disagree
    if (sum_wide[dwps_pkg::ErrW] != sum_wide[dwps_pkg::ErrW-1]) begin
      sum_sat = sum_wide[dwps_pkg::ErrW] ? {1'b1, {(dwps_pkg::ErrW-1){1'b0}}}
                                         : {1'b0, {(dwps_pkg::ErrW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[dwps_pkg::ErrW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed      <= 1'b1;
      count      <= '0;
      last_count <= '0;
      prev_error <= '0;
      error_sum  <= '0;
    end else if (ctrl.load) begin
      armed <= ~level;
      count <= count_next;
      if (ctrl.tick_upd) begin
        last_count <= count_next;
        prev_error <= err_bits;
        error_sum  <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load && ctrl.tick_upd) begin
      s1_err  <= err_bits;
      s1_sum  <= sum_sat;
      s1_diff <= diff_bits;
    end
  end

  // PID stage: three independent products and one add tree
  always_comb begin
    kp_s   = {1'b0, kp};
    ki_s   = {1'b0, ki};
    kd_s   = {1'b0, kd};
    p_term = ProdW'(s1_err) * ProdW'(kp_s);
    i_term = ProdW'(s1_sum) * ProdW'(ki_s);
    d_term = ProdW'(s1_diff) * ProdW'(kd_s);
    acc    = {{(AccW-dwps_pkg::DriveW){1'b0}}, drive}
           + {{2{p_term[ProdW-1]}}, p_term}
           + {{2{i_term[ProdW-1]}}, i_term}
           + {{2{d_term[ProdW-1]}}, d_term};
    if (acc[AccW-1]) begin
      clamped = '0;
    end else if (acc > {{(AccW-dwps_pkg::DriveW){1'b0}}, dwps_pkg::DriveMax}) begin
      clamped = dwps_pkg::DriveMax;
    end else begin
      clamped = acc[dwps_pkg::DriveW-1:0];
    end
    drive_next = ctrl.s1_upd ? clamped : drive;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive <= '0;
    end else if (ctrl.adv) begin
      drive <= drive_next;
    end
  end

  // count holds the front stage word's value until it moves on
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      pulses <= count;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dwps_merge.sv =====
`default_nettype none

module dwps_merge (
  input  wire logic                         clk,
  input  wire logic                         adv,
  input  wire logic [dwps_pkg::DriveW-1:0]  right_next,
  input  wire logic [dwps_pkg::DriveW-1:0]  left_next,
  output logic      [dwps_pkg::DriveW-1:0]  drive_pwm
);

  logic [dwps_pkg::DriveW:0] total;

  assign total = {1'b0, right_next} + {1'b0, left_next};

  always_ff @(posedge clk) begin
    if (adv) begin
      drive_pwm <= total[dwps_pkg::DriveW:1];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dual_wheel_encoder_pid_speed.sv =====
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | right_level, left_level
// out     | out_valid / out_ready| drive_pwm, right_drive, left_drive,
//         |                      | right_pulses, left_pulses, updated
// cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Two stages: front (edge count, tick count, error/sum/diff) and PID
// (three products, add, clamp, mean) which is also the output register.
// One word per cycle unless stalled; out_valid rises as the front word advances.
// A stalled output holds its word while the front stage takes one more.
// Synchronous reset clears valid flags, counters, drives; cfg_ready stays high.
`default_nettype none

module dual_wheel_encoder_pid_speed (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           right_level,
  input  wire logic                           left_level,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [dwps_pkg::DriveW-1:0]    drive_pwm,
  output logic      [dwps_pkg::DriveW-1:0]    right_drive,
  output logic      [dwps_pkg::DriveW-1:0]    left_drive,
  output logic      [dwps_pkg::CountW-1:0]    right_pulses,
  output logic      [dwps_pkg::CountW-1:0]    left_pulses,
  output logic                                updated,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dwps_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [dwps_pkg::CfgDataW-1:0]  cfg_data
);

  logic [dwps_pkg::TargetW-1:0] target_pulses;
  logic [dwps_pkg::PeriodW-1:0] period_ticks;
  logic [dwps_pkg::GainW-1:0]   right_kp, right_ki, right_kd;
  logic [dwps_pkg::GainW-1:0]   left_kp, left_ki, left_kd;

  logic                         s1_valid;
  logic                         s1_upd;
  logic [dwps_pkg::PeriodW-1:0] tick_count;
  logic [dwps_pkg::PeriodW:0]   tick_sum;
  logic                         tick_hit;
  logic                         load;
  logic                         adv;
  dwps_pkg::lane_ctrl_t         ctrl;
  logic [dwps_pkg::DriveW-1:0]  right_next;
  logic [dwps_pkg::DriveW-1:0]  left_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_pulses <= '0;
      period_ticks  <= dwps_pkg::PeriodReset;
      right_kp      <= '0;
      right_ki      <= '0;
      right_kd      <= '0;
      left_kp       <= '0;
      left_ki       <= '0;
      left_kd       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dwps_pkg::RegTarget:  target_pulses <= cfg_data[dwps_pkg::TargetW-1:0];
        dwps_pkg::RegPeriod:  period_ticks  <= cfg_data[dwps_pkg::PeriodW-1:0];
        dwps_pkg::RegRightKp: right_kp      <= cfg_data[dwps_pkg::GainW-1:0];
        dwps_pkg::RegRightKi: right_ki      <= cfg_data[dwps_pkg::GainW-1:0];
        dwps_pkg::RegRightKd: right_kd      <= cfg_data[dwps_pkg::GainW-1:0];
        dwps_pkg::RegLeftKp:  left_kp       <= cfg_data[dwps_pkg::GainW-1:0];
        dwps_pkg::RegLeftKi:  left_ki       <= cfg_data[dwps_pkg::GainW-1:0];
        dwps_pkg::RegLeftKd:  left_kd       <= cfg_data[dwps_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow
  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;
  assign load     = in_valid && in_ready;

  // incremented tick compared without wrap; period zero hits every tick
  assign tick_sum = {1'b0, tick_count} + {{dwps_pkg::PeriodW{1'b0}}, 1'b1};
  assign tick_hit = tick_sum >= {1'b0, period_ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      tick_count <= '0;
    end else begin
      if (load) begin
        s1_valid   <= 1'b1;
        tick_count <= tick_hit ? '0 : tick_sum[dwps_pkg::PeriodW-1:0];
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_upd <= tick_hit;
    end
    if (adv) begin
      updated <= s1_upd;
    end
  end

  always_comb begin
    ctrl.load     = load;
    ctrl.tick_upd = tick_hit;
    ctrl.adv      = adv;
    ctrl.s1_upd   = s1_upd;
  end

  dwps_lane u_right (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .level      (right_level),
    .target     (target_pulses),
    .kp         (right_kp),
    .ki         (right_ki),
    .kd         (right_kd),
    .drive      (right_drive),
    .drive_next (right_next),
    .pulses     (right_pulses)
  );

  dwps_lane u_left (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .level      (left_level),
    .target     (target_pulses),
    .kp         (left_kp),
    .ki         (left_ki),
    .kd         (left_kd),
    .drive      (left_drive),
    .drive_next (left_next),
    .pulses     (left_pulses)
  );

  dwps_merge u_merge (
    .clk        (clk),
    .adv        (adv),
    .right_next (right_next),
    .left_next  (left_next),
    .drive_pwm  (drive_pwm)
  );

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while both stages are full and stalled");

  a_out_from_front: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("output word appeared without a front stage word");

  a_mean_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (((drive_pwm <= right_drive) || (drive_pwm <= left_drive)) &&
                   ((drive_pwm >= right_drive) || (drive_pwm >= left_drive))))
    else $error("common drive outside the two wheel drives");

  a_hold_without_update: assert property (@(posedge clk) disable iff (rst)
    (adv && !s1_upd) |=> ($stable(right_drive) && $stable(left_drive)))
    else $error("wheel drive changed on a word without an update");

endmodule

`default_nettype wire
